[sv/mfa_pkg.sv]
package mfa_pkg;

  typedef enum logic [1:0] {
    FMT_INT8    = 2'd0,
    FMT_INT32   = 2'd1,
    FMT_FLOAT32 = 2'd2,
    FMT_FLOAT64 = 2'd3
  } fmt_t;

  localparam logic [63:0] QNAN32 = 64'h0000_0000_7FC0_0000;
  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;

  // working mantissa: hidden bit + 52 fraction + guard/round/sticky
  localparam int MW = 56;

  // stage 1 -> stage 2: operands unpacked into a common wide form
  typedef struct packed {
    logic        is_int;
    logic        is_f32;
    logic        mismatch;
    logic [63:0] int_sum;
    logic        special;
    logic [63:0] special_bits;
    logic        sign_big;
    logic        sign_small;
    logic [11:0] exp_big;
    logic [52:0] man_big;
    logic [52:0] man_small;
    logic [11:0] exp_diff;
  } s1_t;

  // stage 2 -> stage 3: aligned add done
  typedef struct packed {
    logic        is_int;
    logic        is_f32;
    logic        mismatch;
    logic [63:0] int_sum;
    logic        special;
    logic [63:0] special_bits;
    logic        sign;
    logic [11:0] exp;
    logic [MW:0] sum;
  } s2_t;

  // stage 3 -> stage 4: normalized, before rounding
  typedef struct packed {
    logic        is_int;
    logic        is_f32;
    logic        mismatch;
    logic [63:0] int_sum;
    logic        special;
    logic [63:0] special_bits;
    logic        sign;
    logic        zero;
    logic [12:0] exp;
    logic [MW-1:0] man;
  } s3_t;

endpackage

[sv/mfa_core.sv]
module mfa_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [1:0]  operation,
  input  logic [1:0]  other_format,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        out_valid,
  output logic [63:0] sum_bits,
  output logic        format_mismatch
);

  localparam int MW = mfa_pkg::MW;

  logic [3:0] vld;
  mfa_pkg::s1_t s1, s1_next;
  mfa_pkg::s2_t s2, s2_next;
  mfa_pkg::s3_t s3, s3_next;
  logic [63:0] res, res_next;
  logic        mis;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1  <= s1_next;
      s2  <= s2_next;
      s3  <= s3_next;
      res <= res_next;
      mis <= s3.mismatch;
    end
  end

  assign out_valid       = vld[3];
  assign sum_bits        = res;
  assign format_mismatch = mis;

  // ---- stage 1: unpack, swap, specials, integer sum
  always_comb begin
    logic        f32, sa, sb, nana, nanb, infa, infb, a_big;
    logic [11:0] ea, eb, eea, eeb;
    logic [52:0] ma, mb;
    logic [63:0] isum;
    f32 = (operation == mfa_pkg::FMT_FLOAT32);
    if (f32) begin
      sa = operand_a[31]; sb = operand_b[31];
      ea = {4'd0, operand_a[30:23]}; eb = {4'd0, operand_b[30:23]};
      ma = {1'b0, operand_a[22:0], 29'd0}; mb = {1'b0, operand_b[22:0], 29'd0};
      infa = (ea == 12'hFF); infb = (eb == 12'hFF);
    end else begin
      sa = operand_a[63]; sb = operand_b[63];
      ea = {1'b0, operand_a[62:52]}; eb = {1'b0, operand_b[62:52]};
      ma = {1'b0, operand_a[51:0]}; mb = {1'b0, operand_b[51:0]};
      infa = (ea == 12'h7FF); infb = (eb == 12'h7FF);
    end
    nana = infa && (ma != '0);
    nanb = infb && (mb != '0);
    // hidden bit, subnormals use exponent 1
    eea = (ea == '0) ? 12'd1 : ea;
    eeb = (eb == '0) ? 12'd1 : eb;
    ma[52] = (ea != '0);
    mb[52] = (eb != '0);
    a_big = ({eea, ma} >= {eeb, mb});
    isum = operand_a + operand_b;
    unique case (mfa_pkg::fmt_t'(operation))
      mfa_pkg::FMT_INT8:  isum = {56'd0, isum[7:0]};
      mfa_pkg::FMT_INT32: isum = {32'd0, isum[31:0]};
      default:            isum = isum;
    endcase
    s1_next.is_int     = !operation[1];
    s1_next.is_f32     = f32;
    s1_next.mismatch   = (operation != other_format);
    s1_next.int_sum    = isum;
    s1_next.special    = nana || nanb || infa || infb;
    if (nana || nanb || (infa && infb && (sa != sb)))
      s1_next.special_bits = f32 ? mfa_pkg::QNAN32 : mfa_pkg::QNAN64;
    else if (infa)
      s1_next.special_bits = f32 ? {32'd0, operand_a[31:0]} : operand_a;
    else
      s1_next.special_bits = f32 ? {32'd0, operand_b[31:0]} : operand_b;
    s1_next.sign_big   = a_big ? sa : sb;
    s1_next.sign_small = a_big ? sb : sa;
    s1_next.exp_big    = a_big ? eea : eeb;
    s1_next.man_big    = a_big ? ma : mb;
    s1_next.man_small  = a_big ? mb : ma;
    s1_next.exp_diff   = a_big ? (eea - eeb) : (eeb - eea);
  end

  // ---- stage 2: align and add
  always_comb begin
    logic [MW-1:0] big, sml, sh;
    logic          sticky;
    logic [5:0]    d;
    big   = {s1.man_big, 3'd0};
    sml   = {s1.man_small, 3'd0};
    d = (s1.exp_diff > 12'd56) ? 6'd56 : s1.exp_diff[5:0];
    sh = sml >> d;
    sticky = ((sh << d) != sml);
    sh[0] = sh[0] | sticky;
    s2_next.is_int       = s1.is_int;
    s2_next.is_f32       = s1.is_f32;
    s2_next.mismatch     = s1.mismatch;
    s2_next.int_sum      = s1.int_sum;
    s2_next.special      = s1.special;
    s2_next.special_bits = s1.special_bits;
    s2_next.exp          = s1.exp_big;
    if (s1.sign_big == s1.sign_small) begin
      s2_next.sum  = {1'b0, big} + {1'b0, sh};
      s2_next.sign = s1.sign_big;
    end else begin
      s2_next.sum  = {1'b0, big} - {1'b0, sh};
      // exact cancellation gives +0 under round to nearest
      s2_next.sign = (big == sh) ? 1'b0 : s1.sign_big;
    end
  end

  // ---- stage 3: normalize
  always_comb begin
    logic [5:0]    lz;
    logic [12:0]   e;
    logic [MW-1:0] m;
    logic          found;
    lz = '0; found = 1'b0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (!found && s2.sum[i]) begin
        found = 1'b1;
        lz = 6'(MW - 1 - i);
      end
    end
    e = {1'b0, s2.exp};
    if (s2.sum[MW]) begin
      m = s2.sum[MW:1] | {{(MW-1){1'b0}}, s2.sum[0]};
      e = e + 13'd1;
    end else if ({7'd0, lz} < e) begin
      m = s2.sum[MW-1:0] << lz;
      e = e - {7'd0, lz};
    end else begin
      // subnormal: shift only down to exponent 1, then mark as 0
      m = s2.sum[MW-1:0] << (e[5:0] - 6'd1);
      e = 13'd0;
    end
    s3_next.is_int       = s2.is_int;
    s3_next.is_f32       = s2.is_f32;
    s3_next.mismatch     = s2.mismatch;
    s3_next.int_sum      = s2.int_sum;
    s3_next.special      = s2.special;
    s3_next.special_bits = s2.special_bits;
    s3_next.sign         = s2.sign;
    s3_next.zero         = (s2.sum == '0);
    s3_next.exp          = e;
    s3_next.man          = m;
  end

  // ---- stage 4: round and pack, then select the result
  always_comb begin
    logic [53:0] rm;
    logic        g, st, up;
    logic [12:0] e;
    logic [63:0] f;
    e = s3.exp;
    if (s3.is_f32) begin
      g  = s3.man[31];
      st = (s3.man[30:0] != '0);
      up = g && (st || s3.man[32]);
      rm = {30'd0, s3.man[55:32]} + {53'd0, up};
      if (rm[24]) begin rm = rm >> 1; e = e + 13'd1; end
      else if (e == 13'd0 && rm[23]) e = 13'd1;
      if (e >= 13'd255) f = {32'd0, s3.sign, 8'hFF, 23'd0};
      else f = {32'd0, s3.sign, e[7:0], rm[22:0]};
    end else begin
      g  = s3.man[2];
      st = (s3.man[1:0] != '0);
      up = g && (st || s3.man[3]);
      rm = {1'b0, s3.man[55:3]} + {53'd0, up};
      if (rm[53]) begin rm = rm >> 1; e = e + 13'd1; end
      else if (e == 13'd0 && rm[52]) e = 13'd1;
      if (e >= 13'd2047) f = {s3.sign, 11'h7FF, 52'd0};
      else f = {s3.sign, e[10:0], rm[51:0]};
    end
    if (s3.zero)
      f = s3.is_f32 ? {32'd0, s3.sign, 31'd0} : {s3.sign, 63'd0};
    if (s3.mismatch)     res_next = '0;
    else if (s3.is_int)  res_next = s3.int_sum;
    else if (s3.special) res_next = s3.special_bits;
    else                 res_next = f;
  end

endmodule

[sv/multi_format_adder_unit.sv]
// Each accepted input item passes the register stages s1, s2, s3 and res to a valid result.
// Throughput: one item per cycle while not stalled, as every stage takes a new item.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
// A stall on the master side freezes every stage together.
module multi_format_adder_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: operation[1:0], other_format[3:2], operand_a[67:4], operand_b[131:68]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: sum_bits[63:0], format_mismatch[64]
  output logic [71:0]  m_tdata
);

  logic        adv;
  logic [63:0] sum_bits;
  logic        mismatch;

  // pipeline moves when the output slot is empty or being taken
  assign adv      = m_tready || !m_tvalid;
  assign s_tready = adv;

  mfa_core u_core (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (s_tvalid),
    .operation      (s_tdata[1:0]),
    .other_format   (s_tdata[3:2]),
    .operand_a      (s_tdata[67:4]),
    .operand_b      (s_tdata[131:68]),
    .out_valid      (m_tvalid),
    .sum_bits       (sum_bits),
    .format_mismatch(mismatch)
  );

  assign m_tdata = {7'd0, mismatch, sum_bits};

  // a mismatch always comes with a zero sum
  a_mis_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[63:0] == 64'd0)
    else $error("mismatch with nonzero sum");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // input is stalled only while output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("spurious input stall");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;

  localparam mfa_pkg::fmt_t FMT_INT8    = mfa_pkg::FMT_INT8;
  localparam mfa_pkg::fmt_t FMT_INT32   = mfa_pkg::FMT_INT32;
  localparam mfa_pkg::fmt_t FMT_FLOAT32 = mfa_pkg::FMT_FLOAT32;
  localparam mfa_pkg::fmt_t FMT_FLOAT64 = mfa_pkg::FMT_FLOAT64;

  typedef struct {
    mfa_pkg::fmt_t op;
    mfa_pkg::fmt_t tag_b;
    logic [63:0] a;
    logic [63:0] b;
  } operands_t;

  typedef struct {
    logic [63:0] sum;
    logic        mismatch;
  } sum_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;   // operation, other_format, operand_a, operand_b (low bits up)
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;   // sum_bits, format_mismatch (low bits up)

  operands_t pending_ops[$];
  sum_t      expected_sums[$];
  int        error_count;
  int        cycle_count;
  int        burst_left;
  int        gap_left;
  int        stall_mode;

  multi_format_adder_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // IEEE add, round to nearest even, subnormals kept, NaN made canonical.
  // dbl selects binary64, else binary32 in the low word.
  function automatic logic [63:0] ieee_add(logic [63:0] a, logic [63:0] b, bit dbl);
    int          eb;
    int          mb;
    int          emax;
    int          ea;
    int          eb2;
    int          e;
    int          d;
    logic        sa;
    logic        sb;
    logic        sgn;
    logic        tmp_s;
    logic [63:0] frac_mask;
    logic [63:0] ma;
    logic [63:0] mb2;
    logic [63:0] big;
    logic [63:0] sml;
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] qnan;
    logic        g;
    logic        rest;
    eb = dbl ? 11 : 8;
    mb = dbl ? 52 : 23;
    emax = dbl ? 2047 : 255;
    qnan = dbl ? mfa_pkg::QNAN64 : mfa_pkg::QNAN32;
    frac_mask = (64'd1 << mb) - 1;
    if (!dbl) begin
      a = a & 64'hFFFF_FFFF;
      b = b & 64'hFFFF_FFFF;
    end
    sa = a[eb + mb];
    sb = b[eb + mb];
    ea = int'((a >> mb) & emax);
    eb2 = int'((b >> mb) & emax);
    ma = a & frac_mask;
    mb2 = b & frac_mask;
    if ((ea == emax && ma != 0) || (eb2 == emax && mb2 != 0)) return qnan;
    if (ea == emax && eb2 == emax) return (sa != sb) ? qnan : a;
    if (ea == emax) return a;
    if (eb2 == emax) return b;
    // hidden bit, and three guard/round/sticky bits below the LSB
    ma = ((ea == 0) ? ma : (ma | (64'd1 << mb))) << 3;
    mb2 = ((eb2 == 0) ? mb2 : (mb2 | (64'd1 << mb))) << 3;
    if (ea == 0) ea = 1;
    if (eb2 == 0) eb2 = 1;
    if (eb2 > ea || (eb2 == ea && mb2 > ma)) begin
      big = mb2; sml = ma; e = eb2; d = eb2 - ea; sgn = sb; tmp_s = sa;
    end else begin
      big = ma; sml = mb2; e = ea; d = ea - eb2; sgn = sa; tmp_s = sb;
    end
    if (d > mb + 4) sml = (sml != 0) ? 64'd1 : 64'd0;
    else if (d > 0) sml = (sml >> d) | ((sml & ((64'd1 << d) - 1)) != 0);
    sum = (sgn == tmp_s) ? big + sml : big - sml;
    // exact zero: +0 unless both operands are negative
    if (sum == 0) return 64'(sa & sb) << (eb + mb);
    if (sum[mb + 4]) begin
      sum = (sum >> 1) | (sum & 64'd1);
      e++;
    end
    while (!sum[mb + 3] && e > 1) begin
      sum = sum << 1;
      e--;
    end
    g = sum[2];
    rest = sum[1:0] != 0;
    m = sum >> 3;
    if (g && (rest || m[0])) m++;
    if (m[mb + 1]) begin
      m = m >> 1;
      e++;
    end
    if (e >= emax) return (64'(sgn) << (eb + mb)) | (64'(emax) << mb);
    return (64'(sgn) << (eb + mb)) | (64'(m[mb] ? e : 0) << mb) | (m & frac_mask);
  endfunction

  function automatic sum_t predict_sum(operands_t x);
    sum_t r;
    r.sum = '0;
    r.mismatch = 1'b0;
    if (x.op != x.tag_b) r.mismatch = 1'b1;
    else case (x.op)
      FMT_INT8:    r.sum = 64'((x.a[7:0] + x.b[7:0]) & 8'hFF);
      FMT_INT32:   r.sum = {32'd0, x.a[31:0] + x.b[31:0]};
      FMT_FLOAT32: r.sum = ieee_add(x.a, x.b, 1'b0);
      default:     r.sum = ieee_add(x.a, x.b, 1'b1);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: %s got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic push_op(mfa_pkg::fmt_t op, mfa_pkg::fmt_t tag_b, logic [63:0] a,
                         logic [63:0] b);
    operands_t x;
    x.op = op; x.tag_b = tag_b; x.a = a; x.b = b;
    pending_ops.push_back(x);
  endtask

  // operand picked from a mix of random bits and awkward float patterns
  function automatic logic [63:0] pick_operand(mfa_pkg::fmt_t op);
    logic [63:0] r;
    int          k;
    r = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (op == FMT_FLOAT32) case (k)
      0: r[30:23] = 8'hFF;                       // inf/NaN
      1: r[30:23] = 8'h00;                       // zero/subnormal
      2: r[30:0] = 31'($urandom_range(0, 3));    // tiny
      3: r[30:23] = 8'($urandom_range(250, 254)); // near overflow
      default: r[30:23] = 8'($urandom_range(120, 134));
    endcase
    else if (op == FMT_FLOAT64) case (k)
      0: r[62:52] = 11'h7FF;
      1: r[62:52] = 11'h000;
      2: r[62:0] = 63'($urandom_range(0, 3));
      3: r[62:52] = 11'($urandom_range(2042, 2046));
      default: r[62:52] = 11'($urandom_range(1015, 1031));
    endcase
    return r;
  endfunction

  // stimulus: directed corners, a drain pause, then random traffic
  initial begin
    logic [63:0] a;
    logic [63:0] b;
    mfa_pkg::fmt_t op;
    error_count = 0;
    rst = 1'b1;
    push_op(FMT_INT8, FMT_INT8, 64'hFFFF_FFFF_FFFF_FF7F, 64'hFFFF_FFFF_FFFF_FF01);
    push_op(FMT_INT8, FMT_INT8, 64'hFF, 64'hFF);
    push_op(FMT_INT32, FMT_INT32, 64'h0000_0001_FFFF_FFFF, 64'd1);
    push_op(FMT_INT32, FMT_INT32, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
    push_op(FMT_INT32, FMT_FLOAT64, 64'd5, 64'd6);
    push_op(FMT_FLOAT32, FMT_INT8, 64'h3F80_0000, 64'h3F80_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'hFFFF_FFFF_3F80_0000, 64'h3F80_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h7F80_0000, 64'hFF80_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'hFFC1_2345, 64'h3F80_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h7F7F_FFFF, 64'h7F7F_FFFF);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h0000_0001, 64'h807F_FFFF);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h007F_FFFF, 64'h0000_0001);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h8000_0000, 64'h8000_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h3F80_0001, 64'hBF80_0000);
    push_op(FMT_FLOAT32, FMT_FLOAT32, 64'h4B80_0000, 64'h3F00_0000);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h3FF0_0000_0000_0000, 64'h3CA0_0000_0000_0000);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'hFFF0_0000_0000_0001, 64'd0);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);
    push_op(FMT_FLOAT64, FMT_FLOAT64, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    push_op(FMT_FLOAT64, FMT_INT32, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // hold off until every directed sum is back
    wait (pending_ops.size() == 0 && !s_tvalid && expected_sums.size() == 0);
    for (int i = 0; i < 1950; i++) begin
      op = mfa_pkg::fmt_t'($urandom_range(0, 3));
      a = pick_operand(op);
      b = pick_operand(op);
      case ($urandom_range(0, 9))
        0: push_op(op, mfa_pkg::fmt_t'($urandom_range(0, 3)), a, b);
        1: push_op(op, op, a, a ^ (op == FMT_FLOAT64 ? 64'h8000_0000_0000_0000 :
                                   64'h0000_0000_8000_0000) ^ 64'($urandom_range(0, 3)));
        default: push_op(op, op, a, b);
      endcase
    end
    wait (pending_ops.size() == 0 && !s_tvalid && expected_sums.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_sums.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // driver: bursts of items separated by random gaps, which may be empty
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        operands_t x;
        x = pending_ops.pop_front();
        s_tdata <= {4'd0, x.b, x.a, x.tag_b, x.op};
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: ready follows one of four stall modes, redrawn at random as cycle_count runs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    operands_t x;
    sum_t      want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        x.op = mfa_pkg::fmt_t'(s_tdata[1:0]);
        x.tag_b = mfa_pkg::fmt_t'(s_tdata[3:2]);
        x.a = s_tdata[67:4];
        x.b = s_tdata[131:68];
        expected_sums.push_back(predict_sum(x));
      end
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("unexpected sum", m_tdata[63:0], 64'd0);
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata[63:0] !== want.sum) report_mismatch("sum_bits", m_tdata[63:0], want.sum);
          if (m_tdata[64] !== want.mismatch)
            report_mismatch("format_mismatch", 64'(m_tdata[64]), 64'(want.mismatch));
        end
      end
    end
  end

  initial m_tready = 1'b0;
  initial s_tvalid = 1'b0;
  initial s_tdata = '0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
